@@ design/fcmb_pkg.sv @@
// Shared constants, payload and control types for the fuzzy c-means binarizer.
`timescale 1ns / 1ps
package fcmb_pkg;

    // Frame capacity and fixed field widths.
    localparam int MAX_PIXELS = 65536;
    localparam int PIX_W      = 8;
    localparam int NBINS      = 256;
    localparam int HIST_W     = 17;
    localparam int MEMB_W     = 17;
    localparam int CENT_W     = 24;
    localparam int ITER_W     = 6;
    localparam int THR_W      = 16;
    localparam int PADDR_W    = 3;

    // Fixed-point constants.
    localparam int Q16_ONE  = 65536;
    localparam int Q16_HALF = 32768;
    localparam int BIN_MAX  = 131071;

    // Accumulator widths follow from the frame capacity.
    localparam int CNT_W    = $clog2(MAX_PIXELS + 1);
    localparam int HW_W     = HIST_W + MEMB_W;
    localparam int WSUM_CAP = $clog2(MAX_PIXELS) + MEMB_W;
    localparam int WSUM_W   = (WSUM_CAP > HW_W) ? WSUM_CAP : HW_W;
    localparam int NUM_W    = WSUM_W + PIX_W;
    localparam int DIST_W   = 2 * CENT_W - 1;
    localparam int DSUM_W   = 2 * CENT_W;
    localparam int CHG_W    = 64;
    localparam int DIV_W    = (NUM_W + 17 > 64) ? NUM_W + 17 : 64;
    localparam int QUO_W    = CENT_W;
    localparam int DIV_CNT_W = 5;

    // Reset values of the configuration registers.
    localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(31);
    localparam logic [THR_W-1:0]  STOP_THR_RST = THR_W'(1);

    // Input opcodes.
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    // Result kinds.
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_CLASS  = 1'b1;

    // Register indexes, decoded from paddr[2].
    localparam logic REG_MAX_ITER = 1'b0;
    localparam logic REG_STOP_THR = 1'b1;

    // Divider result targets.
    localparam logic [1:0] DIV_CB   = 2'd0;
    localparam logic [1:0] DIV_CD   = 2'd1;
    localparam logic [1:0] DIV_MEMB = 2'd2;

    typedef struct packed {
        logic             opcode;
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_in_item;

    typedef struct packed {
        logic              result_kind;
        logic              white;
        logic [CENT_W-1:0] bright_centroid;
        logic [CENT_W-1:0] dark_centroid;
        logic [ITER_W-1:0] iterations;
        logic              count_saturated;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             accept;
        logic             sel_pix;
        logic [PIX_W-1:0] bin;
        logic             hist_wr;
        logic             emit_class;
        logic             emit_report;
        logic             clus_init;
        logic             iter_start;
        logic             p1_sq;
        logic             p1_wt;
        logic             p1_acc;
        logic             div_start;
        logic [1:0]       div_sel;
        logic             p2_dst;
        logic             nb_half;
        logic             p2_chg;
        logic             p2_acc;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
        logic div_done;
        logic s_zero;
        logic stop;
        logic out_free;
    } t_dp_stat;

    // Starting bright membership round(v * 65536 / 255) = 257 * v + v[7].
    function automatic logic [MEMB_W-1:0] start_memb(input logic [PIX_W-1:0] v);
        return MEMB_W'({v, v}) + MEMB_W'(v[PIX_W-1]);
    endfunction

endpackage

@@ design/fcmb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fcmb_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/fcmb_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module fcmb_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fcmb_pkg::DIV_W-1:0]    i_numer,
    input  logic [fcmb_pkg::DIV_W-1:0]    i_denom,
    input  logic [fcmb_pkg::DIV_CNT_W-1:0] i_nbits,
    output logic                          o_done,
    output logic [fcmb_pkg::QUO_W-1:0]    o_quo
);

    logic                           r_busy;
    logic                           r_done;
    logic [fcmb_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [fcmb_pkg::DIV_W-1:0]     r_rem;
    logic [fcmb_pkg::DIV_W-1:0]     r_den;
    logic [fcmb_pkg::QUO_W-1:0]     r_quo;
    logic                           fits;

    assign fits = (r_rem >= r_den);

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == fcmb_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift-and-subtract datapath; the divisor starts aligned to the top quotient bit.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_numer;
            r_den <= i_denom << (i_nbits - 1'b1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_den;
            end
            r_quo <= {r_quo[fcmb_pkg::QUO_W-2:0], fits};
            r_den <= r_den >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

`ifndef NO_ASSERTIONS
    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_after_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == fcmb_pkg::DIV_CNT_W'(1)) |=> (o_done && !r_busy))
        else $error("divider did not finish after its last step");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("divider done lasted more than one cycle");
`endif

endmodule

@@ design/fcmb_datapath.sv @@
// Histogram, membership store, clustering arithmetic and result register.
`timescale 1ns / 1ps
module fcmb_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fcmb_pkg::t_in_item            i_in_data,
    input  fcmb_pkg::t_dp_cmd             i_cmd,
    output fcmb_pkg::t_dp_stat            o_stat,
    input  logic [fcmb_pkg::ITER_W-1:0]   i_max_iter,
    input  logic [fcmb_pkg::THR_W-1:0]    i_stop_thr,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output fcmb_pkg::t_out_item           o_out_data
);

    // Latched item and frame bookkeeping.
    logic [fcmb_pkg::PIX_W-1:0]  r_pix;
    logic                        r_last;
    logic                        r_frame_open;
    logic [fcmb_pkg::CNT_W-1:0]  r_pcount;
    logic                        r_over;
    logic [fcmb_pkg::NBINS-1:0]  r_hist_vld;
    logic [fcmb_pkg::NBINS-1:0]  r_memb_vld;

    // Read port bookkeeping.
    logic [fcmb_pkg::PIX_W-1:0]  rd_addr;
    logic [fcmb_pkg::PIX_W-1:0]  r_rd_addr;
    logic                        r_hv;
    logic                        r_mv;
    logic [fcmb_pkg::HIST_W-1:0] hist_rdata;
    logic [fcmb_pkg::MEMB_W-1:0] memb_rdata;
    logic [fcmb_pkg::HIST_W-1:0] h;
    logic [fcmb_pkg::MEMB_W-1:0] m;
    logic                        room;
    logic                        bin_ok;
    logic                        hist_we;

    // Clustering registers.
    logic [fcmb_pkg::ITER_W-1:0] r_iter;
    logic [fcmb_pkg::HIST_W-1:0] r_h;
    logic [2*fcmb_pkg::MEMB_W-1:0] r_sq_b;
    logic [2*fcmb_pkg::MEMB_W-1:0] r_sq_d;
    logic [fcmb_pkg::HW_W-1:0]   r_hw_b;
    logic [fcmb_pkg::HW_W-1:0]   r_hw_d;
    logic [fcmb_pkg::WSUM_W-1:0] r_wsum_b;
    logic [fcmb_pkg::WSUM_W-1:0] r_wsum_d;
    logic [fcmb_pkg::NUM_W-1:0]  r_num_b;
    logic [fcmb_pkg::NUM_W-1:0]  r_num_d;
    logic [fcmb_pkg::CENT_W-1:0] r_cb;
    logic [fcmb_pkg::CENT_W-1:0] r_cd;
    logic [fcmb_pkg::DIST_W-1:0] r_db;
    logic [fcmb_pkg::DIST_W-1:0] r_dd;
    logic [fcmb_pkg::MEMB_W-1:0] r_mold;
    logic [fcmb_pkg::MEMB_W-1:0] r_nb;
    logic [fcmb_pkg::MEMB_W-1:0] r_dm;
    logic [fcmb_pkg::HW_W-1:0]   r_hdm;
    logic [fcmb_pkg::CHG_W-1:0]  r_change;
    logic [1:0]                  r_div_sel;

    // Combinational helpers.
    logic [fcmb_pkg::MEMB_W-1:0] m_dark;
    logic [fcmb_pkg::MEMB_W-1:0] wb;
    logic [fcmb_pkg::MEMB_W-1:0] wd;
    logic [fcmb_pkg::NUM_W-1:0]  hwv_b;
    logic [fcmb_pkg::NUM_W-1:0]  hwv_d;
    logic [fcmb_pkg::CENT_W-1:0] vq;
    logic [fcmb_pkg::CENT_W-1:0] diff_b;
    logic [fcmb_pkg::CENT_W-1:0] diff_d;
    logic [fcmb_pkg::DSUM_W-1:0] sq_db;
    logic [fcmb_pkg::DSUM_W-1:0] sq_dd;
    logic [fcmb_pkg::DSUM_W-1:0] s;
    logic [fcmb_pkg::MEMB_W-1:0] dm;
    logic [50:0]                 chg_p;

    // Divider connections.
    logic [fcmb_pkg::DIV_W-1:0]     div_numer;
    logic [fcmb_pkg::DIV_W-1:0]     div_denom;
    logic [fcmb_pkg::DIV_CNT_W-1:0] div_nbits;
    logic                           div_done;
    logic [fcmb_pkg::QUO_W-1:0]     div_quo;

    // Result register.
    logic                        r_out_valid;
    fcmb_pkg::t_out_item         r_out;
    logic                        out_free;

    assign rd_addr = i_cmd.sel_pix ? r_pix : i_cmd.bin;

    fcmb_ram #(.WIDTH(fcmb_pkg::HIST_W), .DEPTH(fcmb_pkg::NBINS)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (r_pix),
        .i_wdata (h + 1'b1),
        .i_raddr (rd_addr),
        .o_rdata (hist_rdata)
    );

    fcmb_ram #(.WIDTH(fcmb_pkg::MEMB_W), .DEPTH(fcmb_pkg::NBINS)) u_memb_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.p2_chg),
        .i_waddr (i_cmd.bin),
        .i_wdata (r_nb),
        .i_raddr (rd_addr),
        .o_rdata (memb_rdata)
    );

    // Entries not written since their clear read as zero count or start membership.
    assign h = r_hv ? hist_rdata : '0;
    assign m = r_mv ? memb_rdata : fcmb_pkg::start_memb(r_rd_addr);

    assign room    = (r_pcount < fcmb_pkg::CNT_W'(fcmb_pkg::MAX_PIXELS));
    assign bin_ok  = (h < fcmb_pkg::HIST_W'(fcmb_pkg::BIN_MAX));
    assign hist_we = i_cmd.hist_wr && room && bin_ok;

    // Read tags follow the registered RAM data.
    always_ff @(posedge i_clk) begin
        r_rd_addr <= rd_addr;
        r_hv      <= r_hist_vld[rd_addr];
        r_mv      <= r_memb_vld[rd_addr];
    end

    // Frame state, valid bits and the iteration counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_pcount     <= '0;
            r_over       <= 1'b0;
            r_hist_vld   <= '0;
            r_memb_vld   <= '0;
            r_iter       <= '0;
        end else begin
            if (i_cmd.accept && i_in_data.opcode == fcmb_pkg::OP_LOAD && !r_frame_open) begin
                r_frame_open <= 1'b1;
                r_pcount     <= '0;
                r_over       <= 1'b0;
                r_hist_vld   <= '0;
            end
            if (i_cmd.hist_wr) begin
                if (room) begin
                    r_pcount <= r_pcount + 1'b1;
                    if (bin_ok) begin
                        r_hist_vld[r_pix] <= 1'b1;
                    end else begin
                        r_over <= 1'b1;
                    end
                end else begin
                    r_over <= 1'b1;
                end
            end
            if (i_cmd.emit_report) begin
                r_frame_open <= 1'b0;
            end
            if (i_cmd.clus_init) begin
                r_memb_vld <= '0;
                r_iter     <= '0;
            end
            if (i_cmd.iter_start) begin
                r_iter <= r_iter + 1'b1;
            end
            if (i_cmd.p2_chg) begin
                r_memb_vld[i_cmd.bin] <= 1'b1;
            end
        end
    end

    // Latch the accepted item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix  <= i_in_data.pixel;
            r_last <= i_in_data.last;
        end
    end

    // First pass: squared memberships, weights and weighted sums.
    assign m_dark = fcmb_pkg::MEMB_W'(fcmb_pkg::Q16_ONE) - m;
    assign wb = fcmb_pkg::MEMB_W'((r_sq_b + 34'd32768) >> 16);
    assign wd = fcmb_pkg::MEMB_W'((r_sq_d + 34'd32768) >> 16);
    assign hwv_b = fcmb_pkg::NUM_W'(r_hw_b) * fcmb_pkg::NUM_W'(i_cmd.bin);
    assign hwv_d = fcmb_pkg::NUM_W'(r_hw_d) * fcmb_pkg::NUM_W'(i_cmd.bin);

    always_ff @(posedge i_clk) begin
        if (i_cmd.p1_sq) begin
            r_sq_b <= m * m;
            r_sq_d <= m_dark * m_dark;
            r_h    <= h;
        end
        if (i_cmd.p2_dst) begin
            r_h    <= h;
            r_mold <= m;
        end
        if (i_cmd.p1_wt) begin
            r_hw_b <= r_h * wb;
            r_hw_d <= r_h * wd;
        end
        if (i_cmd.iter_start) begin
            r_wsum_b <= '0;
            r_wsum_d <= '0;
            r_num_b  <= '0;
            r_num_d  <= '0;
            r_change <= '0;
        end
        if (i_cmd.p1_acc) begin
            r_wsum_b <= r_wsum_b + fcmb_pkg::WSUM_W'(r_hw_b);
            r_wsum_d <= r_wsum_d + fcmb_pkg::WSUM_W'(r_hw_d);
            r_num_b  <= r_num_b + hwv_b;
            r_num_d  <= r_num_d + hwv_d;
        end
        if (i_cmd.p2_acc) begin
            r_change <= r_change + fcmb_pkg::CHG_W'({chg_p, 1'b0});
        end
    end

    // Second pass: distances to both centroids.
    assign vq     = {i_cmd.bin, 16'b0};
    assign diff_b = (r_cb > vq) ? r_cb - vq : vq - r_cb;
    assign diff_d = (r_cd > vq) ? r_cd - vq : vq - r_cd;
    assign sq_db  = fcmb_pkg::DSUM_W'(diff_b) * fcmb_pkg::DSUM_W'(diff_b);
    assign sq_dd  = fcmb_pkg::DSUM_W'(diff_d) * fcmb_pkg::DSUM_W'(diff_d);
    assign s      = fcmb_pkg::DSUM_W'(r_db) + fcmb_pkg::DSUM_W'(r_dd);

    always_ff @(posedge i_clk) begin
        if (i_cmd.p2_dst) begin
            r_db <= fcmb_pkg::DIST_W'(sq_db >> 1);
            r_dd <= fcmb_pkg::DIST_W'(sq_dd >> 1);
        end
    end

    // Divider operands: rounded centroid or rounded new membership.
    always_comb begin
        unique case (i_cmd.div_sel)
            fcmb_pkg::DIV_CB: begin
                div_numer = fcmb_pkg::DIV_W'({r_num_b, 16'b0})
                          + fcmb_pkg::DIV_W'(r_wsum_b >> 1);
                div_denom = fcmb_pkg::DIV_W'(r_wsum_b);
                div_nbits = fcmb_pkg::DIV_CNT_W'(fcmb_pkg::CENT_W);
            end
            fcmb_pkg::DIV_CD: begin
                div_numer = fcmb_pkg::DIV_W'({r_num_d, 16'b0})
                          + fcmb_pkg::DIV_W'(r_wsum_d >> 1);
                div_denom = fcmb_pkg::DIV_W'(r_wsum_d);
                div_nbits = fcmb_pkg::DIV_CNT_W'(fcmb_pkg::CENT_W);
            end
            default: begin
                div_numer = fcmb_pkg::DIV_W'({r_dd, 16'b0}) + fcmb_pkg::DIV_W'(s >> 1);
                div_denom = fcmb_pkg::DIV_W'(s);
                div_nbits = fcmb_pkg::DIV_CNT_W'(fcmb_pkg::MEMB_W);
            end
        endcase
    end

    fcmb_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_numer (div_numer),
        .i_denom (div_denom),
        .i_nbits (div_nbits),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Capture divider results; a zero weight sum gives a zero centroid.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
        end
        if (i_cmd.nb_half) begin
            r_nb <= fcmb_pkg::MEMB_W'(fcmb_pkg::Q16_HALF);
        end
        if (div_done) begin
            unique case (r_div_sel)
                fcmb_pkg::DIV_CB: r_cb <= (r_wsum_b == '0) ? '0 : div_quo;
                fcmb_pkg::DIV_CD: r_cd <= (r_wsum_d == '0) ? '0 : div_quo;
                default:          r_nb <= div_quo[fcmb_pkg::MEMB_W-1:0];
            endcase
        end
    end

    // Membership change, weighted by the bin count.
    assign dm    = (r_nb > r_mold) ? r_nb - r_mold : r_mold - r_nb;
    assign chg_p = 51'(r_hdm) * 51'(r_dm);

    always_ff @(posedge i_clk) begin
        if (i_cmd.p2_chg) begin
            r_hdm <= r_h * dm;
            r_dm  <= dm;
        end
    end

    // Result register parts the output channel from the work.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_class || i_cmd.emit_report) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_class) begin
            r_out.result_kind     <= fcmb_pkg::KIND_CLASS;
            r_out.white           <= (m > fcmb_pkg::MEMB_W'(fcmb_pkg::Q16_HALF));
            r_out.bright_centroid <= '0;
            r_out.dark_centroid   <= '0;
            r_out.iterations      <= '0;
            r_out.count_saturated <= 1'b0;
        end else if (i_cmd.emit_report) begin
            r_out.result_kind     <= fcmb_pkg::KIND_REPORT;
            r_out.white           <= 1'b0;
            r_out.bright_centroid <= r_cb;
            r_out.dark_centroid   <= r_cd;
            r_out.iterations      <= r_iter;
            r_out.count_saturated <= r_over;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Status back to the controller.
    assign o_stat.last     = r_last;
    assign o_stat.div_done = div_done;
    assign o_stat.s_zero   = (s == '0);
    assign o_stat.stop     = (r_iter >= i_max_iter)
                          || (r_change <= fcmb_pkg::CHG_W'({i_stop_thr, 32'b0}));
    assign o_stat.out_free = out_free;

endmodule

@@ design/fcmb_ctrl.sv @@
// Controller state machine that sequences loads, classifies and clustering passes.
`timescale 1ns / 1ps
module fcmb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_opcode,
    output logic               o_in_stall,
    output fcmb_pkg::t_dp_cmd  o_cmd,
    input  fcmb_pkg::t_dp_stat i_stat
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_LD_RD    = 5'd1;
    localparam logic [4:0] S_LD_WR    = 5'd2;
    localparam logic [4:0] S_CL_RD    = 5'd3;
    localparam logic [4:0] S_CL_OUT   = 5'd4;
    localparam logic [4:0] S_IT_INIT  = 5'd5;
    localparam logic [4:0] S_IT_START = 5'd6;
    localparam logic [4:0] S_P1_RD    = 5'd7;
    localparam logic [4:0] S_P1_SQ    = 5'd8;
    localparam logic [4:0] S_P1_WT    = 5'd9;
    localparam logic [4:0] S_P1_ACC   = 5'd10;
    localparam logic [4:0] S_CB_START = 5'd11;
    localparam logic [4:0] S_CB_WAIT  = 5'd12;
    localparam logic [4:0] S_CD_START = 5'd13;
    localparam logic [4:0] S_CD_WAIT  = 5'd14;
    localparam logic [4:0] S_P2_RD    = 5'd15;
    localparam logic [4:0] S_P2_DST   = 5'd16;
    localparam logic [4:0] S_P2_DIV   = 5'd17;
    localparam logic [4:0] S_P2_WAIT  = 5'd18;
    localparam logic [4:0] S_P2_CHG   = 5'd19;
    localparam logic [4:0] S_P2_ACC   = 5'd20;
    localparam logic [4:0] S_IT_END   = 5'd21;
    localparam logic [4:0] S_REPORT   = 5'd22;

    logic [4:0]                 r_state;
    logic [4:0]                 n_state;
    logic [fcmb_pkg::PIX_W-1:0] r_bin;
    logic [fcmb_pkg::PIX_W-1:0] n_bin;
    logic                       bin_last;

    assign bin_last = (r_bin == {fcmb_pkg::PIX_W{1'b1}});

    // Next state, bin counter and commands.
    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        o_cmd   = '0;
        o_cmd.bin = r_bin;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_opcode == fcmb_pkg::OP_LOAD) ? S_LD_RD : S_CL_RD;
                end
            end
            S_LD_RD: begin
                o_cmd.sel_pix = 1'b1;
                n_state = S_LD_WR;
            end
            S_LD_WR: begin
                o_cmd.sel_pix = 1'b1;
                o_cmd.hist_wr = 1'b1;
                n_state = i_stat.last ? S_IT_INIT : S_IDLE;
            end
            S_CL_RD: begin
                o_cmd.sel_pix = 1'b1;
                n_state = S_CL_OUT;
            end
            S_CL_OUT: begin
                o_cmd.sel_pix = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.emit_class = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_IT_INIT: begin
                o_cmd.clus_init = 1'b1;
                n_state = S_IT_START;
            end
            S_IT_START: begin
                o_cmd.iter_start = 1'b1;
                n_bin   = '0;
                n_state = S_P1_RD;
            end
            S_P1_RD: begin
                n_state = S_P1_SQ;
            end
            S_P1_SQ: begin
                o_cmd.p1_sq = 1'b1;
                n_state = S_P1_WT;
            end
            S_P1_WT: begin
                o_cmd.p1_wt = 1'b1;
                n_state = S_P1_ACC;
            end
            S_P1_ACC: begin
                o_cmd.p1_acc = 1'b1;
                n_bin   = r_bin + 1'b1;
                n_state = bin_last ? S_CB_START : S_P1_RD;
            end
            S_CB_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = fcmb_pkg::DIV_CB;
                n_state = S_CB_WAIT;
            end
            S_CB_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_CD_START;
                end
            end
            S_CD_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = fcmb_pkg::DIV_CD;
                n_state = S_CD_WAIT;
            end
            S_CD_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_P2_RD;
                end
            end
            S_P2_RD: begin
                n_state = S_P2_DST;
            end
            S_P2_DST: begin
                o_cmd.p2_dst = 1'b1;
                n_state = S_P2_DIV;
            end
            S_P2_DIV: begin
                o_cmd.div_sel = fcmb_pkg::DIV_MEMB;
                if (i_stat.s_zero) begin
                    o_cmd.nb_half = 1'b1;
                    n_state = S_P2_CHG;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_P2_WAIT;
                end
            end
            S_P2_WAIT: begin
                o_cmd.div_sel = fcmb_pkg::DIV_MEMB;
                if (i_stat.div_done) begin
                    n_state = S_P2_CHG;
                end
            end
            S_P2_CHG: begin
                o_cmd.p2_chg = 1'b1;
                n_state = S_P2_ACC;
            end
            S_P2_ACC: begin
                o_cmd.p2_acc = 1'b1;
                n_bin   = r_bin + 1'b1;
                n_state = bin_last ? S_IT_END : S_P2_RD;
            end
            S_IT_END: begin
                n_state = i_stat.stop ? S_REPORT : S_IT_START;
            end
            S_REPORT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_report = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bin   <= '0;
        end else begin
            r_state <= n_state;
            r_bin   <= n_bin;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ design/fuzzy_cmeans_binarizer.sv @@
// Top level of the fuzzy c-means binarizer: configuration registers and block wiring.
//
// Input channel: one beat carries opcode, pixel and last. A load beat adds the
// pixel to a 256-bin histogram; the first load after a report opens a new frame.
// A load beat with last set runs two-cluster clustering and yields one report
// beat; a classify beat yields one beat whose white bit says bright or dark.
// A load occupies the block for the accept cycle, a histogram read and a
// histogram write. A classify beat takes the accept cycle, a membership read
// and an output state that waits for a free output register. Clustering runs
// per iteration a start and an end state, a first pass that reads, squares,
// weights and accumulates each bin, a serial division per centroid, and a
// second pass per bin around one 17-step division (replaced by one half
// when both distances are zero). The block takes one item at a time; stall
// is high until it is done. A result waits in an output register while the
// receiver stalls; the block holds the next result until that register is free.
// Reset empties the frame, restores the starting memberships (v / 255) and
// sets max_iterations to 31 and stop_threshold to 1. The APB port writes
// max_iterations at address 0 and stop_threshold at address 4.
`timescale 1ns / 1ps
module fuzzy_cmeans_binarizer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  fcmb_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output fcmb_pkg::t_out_item            o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fcmb_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic [fcmb_pkg::ITER_W-1:0] r_max_iter;
    logic [fcmb_pkg::THR_W-1:0]  r_stop_thr;
    fcmb_pkg::t_dp_cmd           cmd;
    fcmb_pkg::t_dp_stat          stat;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= fcmb_pkg::MAX_ITER_RST;
            r_stop_thr <= fcmb_pkg::STOP_THR_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                fcmb_pkg::REG_MAX_ITER: r_max_iter <= pwdata[fcmb_pkg::ITER_W-1:0];
                fcmb_pkg::REG_STOP_THR: r_stop_thr <= pwdata[fcmb_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[2])
            fcmb_pkg::REG_MAX_ITER: prdata = 32'(r_max_iter);
            fcmb_pkg::REG_STOP_THR: prdata = 32'(r_stop_thr);
            default:                prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    fcmb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_data.opcode),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    fcmb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_max_iter  (r_max_iter),
        .i_stop_thr  (r_stop_thr),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
